// ----- hw/rtl/ihv_pkg.sv -----
`timescale 1ns / 1ps

package ihv_pkg;

	localparam int unsigned HEADER_BYTES = 16;
	localparam int unsigned POS_W        = 5;
	localparam int unsigned CFG_INDEX_W  = 2;
	localparam int unsigned LEN_W        = 24;
	localparam int unsigned SIZE_W       = 23;

	typedef logic [1:0] verdict_t;
	localparam verdict_t VERDICT_OK          = 2'd0;
	localparam verdict_t VERDICT_BAD         = 2'd1;
	localparam verdict_t VERDICT_UNSUPPORTED = 2'd2;

	typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
	localparam cfg_index_t REG_FILE_LENGTH      = 2'd0;
	localparam cfg_index_t REG_MAX_IMAGE_LENGTH = 2'd1;

	localparam logic [LEN_W-1:0] MAX_IMAGE_LENGTH_RST = 24'd8388608;

	typedef logic [HEADER_BYTES-1:0][7:0] hdr_t;

	localparam logic [3:0][7:0] MAGIC_TAG  = {8'h1a, 8'h53, 8'h45, 8'h4e};
	localparam logic [8:0][7:0] RIPPER_TAG =
		{8'h21, 8'h65, 8'h64, 8'h75, 8'h44, 8'h6b, 8'h73, 8'h69, 8'h44};

	// Header handed from the capture stage to the checker
	typedef struct packed {
		logic pend;
		hdr_t hdr;
	} judge_req_t;

endpackage

// ----- hw/rtl/ihv_if.sv -----
`timescale 1ns / 1ps

interface ihv_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] header_byte;
	logic       first_byte;

	modport source (output valid, header_byte, first_byte, input ready);
	modport sink   (input valid, header_byte, first_byte, output ready);
endinterface

interface ihv_verdict_if;
	logic        valid;
	logic        ready;
	logic [1:0]  verdict;
	logic [7:0]  mapper_id;
	logic [22:0] image_size;

	modport source (output valid, verdict, mapper_id, image_size, input ready);
	modport sink   (input valid, verdict, mapper_id, image_size, output ready);
endinterface

interface ihv_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [23:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/ihv_capture.sv -----
`timescale 1ns / 1ps

module ihv_capture (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_fire,
	input  logic [7:0]          header_byte,
	input  logic                first_byte,
	input  logic                adv,
	output logic                hold,
	output ihv_pkg::judge_req_t req
);

	logic [ihv_pkg::POS_W-1:0] pos_q;
	logic [ihv_pkg::POS_W-1:0] pos_eff;
	logic                      in_range;
	logic                      last;
	logic                      pend_s1;
	ihv_pkg::hdr_t             hdr_q;

	assign pos_eff  = first_byte ? '0 : pos_q;
	assign in_range = (pos_eff < ihv_pkg::POS_W'(ihv_pkg::HEADER_BYTES));
	assign last     = (pos_eff == ihv_pkg::POS_W'(ihv_pkg::HEADER_BYTES - 1));

	// Stall new beats only while a finished header cannot move on
	assign hold = pend_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			pend_s1 <= 1'b0;
		end else begin
			if (in_fire) begin
				pos_q <= in_range ? pos_eff + 1'b1 : pos_eff;
			end
			pend_s1 <= (in_fire && last) || hold;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && in_range) begin
			hdr_q[pos_eff[3:0]] <= header_byte;
		end
	end

	assign req.pend = pend_s1;
	assign req.hdr  = hdr_q;

	pos_bound_a: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= ihv_pkg::POS_W'(ihv_pkg::HEADER_BYTES))
		else $error("byte position past header end");

	pend_after_last_a: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pend_s1) |-> pos_q == ihv_pkg::POS_W'(ihv_pkg::HEADER_BYTES))
		else $error("verdict pending without a complete header");

	hold_blocks_a: assert property (@(posedge clk) disable iff (!arst_n)
		hold |-> !in_fire)
		else $error("beat taken while a header waits");

endmodule

// ----- hw/rtl/ihv_judge.sv -----
`timescale 1ns / 1ps

module ihv_judge (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ihv_pkg::judge_req_t        req,
	input  logic [ihv_pkg::LEN_W-1:0]  file_length,
	input  logic [ihv_pkg::LEN_W-1:0]  max_image_length,
	input  logic                       out_ready,
	output logic                       adv,
	output logic                       out_valid,
	output ihv_pkg::verdict_t          verdict,
	output logic [7:0]                 mapper_id,
	output logic [ihv_pkg::SIZE_W-1:0] image_size
);

	function automatic logic mapper_ok(input logic [7:0] m);
		logic ok;
		case (m)
			8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd7,
			8'd9, 8'd10, 8'd11, 8'd23, 8'd24, 8'd66: ok = 1'b1;
			default: ok = 1'b0;
		endcase
		return ok;
	endfunction

	ihv_pkg::hdr_t                hdr;
	logic                         ripper;
	logic                         magic_ok;
	logic [7:0]                   mapper;
	logic [ihv_pkg::SIZE_W-1:0]   total;
	ihv_pkg::verdict_t            verdict_d;
	logic                         take;
	logic                         out_valid_q;
	ihv_pkg::verdict_t            verdict_q;
	logic [7:0]                   mapper_q;
	logic [ihv_pkg::SIZE_W-1:0]   size_q;

	assign hdr      = req.hdr;
	assign ripper   = ({hdr[15], hdr[14], hdr[13], hdr[12], hdr[11], hdr[10], hdr[9],
	                    hdr[8], hdr[7]} == ihv_pkg::RIPPER_TAG);
	assign magic_ok = ({hdr[3], hdr[2], hdr[1], hdr[0]} == ihv_pkg::MAGIC_TAG);
	assign mapper   = {ripper ? 4'h0 : hdr[7][7:4], hdr[6][7:4]};

	// 16 + trainer + 16 KiB per PRG bank + 8 KiB per CHR bank
	assign total = ihv_pkg::SIZE_W'(16)
	             + (hdr[6][2] ? ihv_pkg::SIZE_W'(512) : '0)
	             + {1'b0, hdr[4], 14'd0}
	             + {2'b0, hdr[5], 13'd0};

	always_comb begin
		if (file_length < ihv_pkg::LEN_W'(16) || file_length > max_image_length || !magic_ok)
			verdict_d = ihv_pkg::VERDICT_BAD;
		else if ((hdr[7] & 8'h0c) == 8'h08)
			verdict_d = ihv_pkg::VERDICT_UNSUPPORTED;
		else if (!ripper && hdr[7][3:0] != 4'h0)
			verdict_d = ihv_pkg::VERDICT_UNSUPPORTED;
		else if (!ripper && (hdr[12] | hdr[13] | hdr[14] | hdr[15]) != 8'h00)
			verdict_d = ihv_pkg::VERDICT_BAD;
		else if (hdr[4] == 8'h00)
			verdict_d = ihv_pkg::VERDICT_BAD;
		else if (!ripper && hdr[8] > 8'd8)
			verdict_d = ihv_pkg::VERDICT_UNSUPPORTED;
		else if (!mapper_ok(mapper))
			verdict_d = ihv_pkg::VERDICT_UNSUPPORTED;
		else if ({1'b0, total} > file_length)
			verdict_d = ihv_pkg::VERDICT_BAD;
		else
			verdict_d = ihv_pkg::VERDICT_OK;
	end

	assign adv  = !out_valid_q || out_ready;
	assign take = req.pend && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= take || (out_valid_q && !out_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			verdict_q <= verdict_d;
			mapper_q  <= mapper;
			size_q    <= (verdict_d == ihv_pkg::VERDICT_OK) ? total : '0;
		end
	end

	assign out_valid  = out_valid_q;
	assign verdict    = verdict_q;
	assign mapper_id  = mapper_q;
	assign image_size = size_q;

	ok_has_size_a: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && verdict_q == ihv_pkg::VERDICT_OK |-> size_q != '0)
		else $error("accepted image with zero size");

	reject_no_size_a: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && verdict_q != ihv_pkg::VERDICT_OK |-> size_q == '0)
		else $error("rejected image carries a size");

	stall_keeps_a: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q && $stable(verdict_q))
		else $error("result lost under stall");

endmodule

// ----- hw/rtl/ines_header_validator_unit.sv -----
`timescale 1ns / 1ps
// Cartridge image header checker.
// in_ch: one header byte per beat, offsets 0 to 15; first_byte marks offset 0
//   and restarts the byte count. Beats past offset 15 without the mark are
//   taken and dropped.
// out_ch: one beat per complete header: verdict (0 ok, 1 bad, 2 unsupported),
//   mapper number and image size (zero unless accepted).
// cfg: write index 0 for file_length, 1 for max_image_length; other indexes are
//   taken and dropped. Write only while no header is in flight.
// Throughput: one header byte per cycle while in_ch.ready is high. The checks
//   sit between the stored header bytes and the result register, which fills
//   once the beat carrying offset 15 is taken and the register is free.
// Reset clears the byte count, the result valid and sets max_image_length to
//   8388608 and file_length to 0.
// Receiver stall: the result is held; input keeps flowing until a second
//   complete header waits behind it, then in_ch.ready drops.

module ines_header_validator_unit (
	input  logic   clk,
	input  logic   arst_n,
	ihv_byte_if.sink      in_ch,
	ihv_verdict_if.source out_ch,
	ihv_cfg_if.sink       cfg
);

	logic                       in_fire;
	logic                       hold;
	logic                       adv;
	ihv_pkg::judge_req_t        req;
	logic [ihv_pkg::LEN_W-1:0]  file_length_q;
	logic [ihv_pkg::LEN_W-1:0]  max_image_length_q;

	assign cfg.ready   = 1'b1;
	assign in_ch.ready = !hold;
	assign in_fire     = in_ch.valid && !hold;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_length_q      <= '0;
			max_image_length_q <= ihv_pkg::MAX_IMAGE_LENGTH_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				ihv_pkg::REG_FILE_LENGTH:      file_length_q      <= cfg.data;
				ihv_pkg::REG_MAX_IMAGE_LENGTH: max_image_length_q <= cfg.data;
				default: ;
			endcase
		end
	end

	ihv_capture u_capture (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_fire     (in_fire),
		.header_byte (in_ch.header_byte),
		.first_byte  (in_ch.first_byte),
		.adv         (adv),
		.hold        (hold),
		.req         (req)
	);

	ihv_judge u_judge (
		.clk              (clk),
		.arst_n           (arst_n),
		.req              (req),
		.file_length      (file_length_q),
		.max_image_length (max_image_length_q),
		.out_ready        (out_ch.ready),
		.adv              (adv),
		.out_valid        (out_ch.valid),
		.verdict          (out_ch.verdict),
		.mapper_id        (out_ch.mapper_id),
		.image_size       (out_ch.image_size)
	);

endmodule

// ----- tb/ihv_header_checker.sv -----
`timescale 1ns / 1ps

module ihv_header_checker
	import ihv_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  header_byte,
	input  logic        first_byte,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [1:0]  verdict,
	input  logic [7:0]  mapper_id,
	input  logic [22:0] image_size,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data,
	output int          mismatches,
	output int          pending
);

	typedef struct packed {
		verdict_t    verdict;
		logic [7:0]  mapper;
		logic [22:0] size;
	} verdict_beat_t;

	verdict_beat_t      expected_verdicts[$];
	verdict_beat_t      want;
	verdict_beat_t      got;
	hdr_t               stored_hdr;
	logic [POS_W-1:0]   next_pos;
	logic [LEN_W-1:0]   file_len;
	logic [LEN_W-1:0]   max_len;
	int                 err_count;

	function automatic logic mapper_supported(logic [7:0] m);
		case (m)
			8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd7,
			8'd9, 8'd10, 8'd11, 8'd23, 8'd24, 8'd66: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic verdict_beat_t grade_header(hdr_t h, logic [LEN_W-1:0] flen,
			logic [LEN_W-1:0] maxl);
		verdict_beat_t r;
		logic          ripper;
		int unsigned   total;
		ripper   = (h[15:7] == RIPPER_TAG);
		// the ripper tag overwrites byte 7, so its high nibble is not mapper data
		r.mapper = {ripper ? 4'h0 : h[7][7:4], h[6][7:4]};
		r.size   = '0;
		total    = 32'd16 + (h[6][2] ? 32'd512 : 32'd0)
			+ 32'(h[4]) * 32'd16384 + 32'(h[5]) * 32'd8192;
		if (flen < 16 || flen > maxl || h[3:0] != MAGIC_TAG)
			r.verdict = VERDICT_BAD;
		else if (h[7][3:2] == 2'b10)
			r.verdict = VERDICT_UNSUPPORTED;
		else if (!ripper && h[7][3:0] != 4'h0)
			r.verdict = VERDICT_UNSUPPORTED;
		else if (!ripper && (h[12] | h[13] | h[14] | h[15]) != 8'h00)
			r.verdict = VERDICT_BAD;
		else if (h[4] == 8'h00)
			r.verdict = VERDICT_BAD;
		else if (!ripper && h[8] > 8'd8)
			r.verdict = VERDICT_UNSUPPORTED;
		else if (!mapper_supported(r.mapper))
			r.verdict = VERDICT_UNSUPPORTED;
		else if (total > 32'(flen))
			r.verdict = VERDICT_BAD;
		else begin
			r.verdict = VERDICT_OK;
			r.size    = total[22:0];
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_verdicts.delete();
			stored_hdr = '0;
			next_pos   = '0;
			file_len   = '0;
			max_len    = MAX_IMAGE_LENGTH_RST;
			err_count  = 0;
			mismatches <= 0;
			pending    <= 0;
		end else begin
			if (out_valid && out_ready) begin
				got = '{verdict: verdict, mapper: mapper_id, size: image_size};
				if (expected_verdicts.size() == 0) begin
					err_count++;
					if (err_count <= 10)
						$display("%0t: unexpected verdict beat: verdict %0d mapper %0d size %0d",
							$realtime, got.verdict, got.mapper, got.size);
				end else begin
					want = expected_verdicts.pop_front();
					if (want != got) begin
						err_count++;
						if (err_count <= 10)
							$display({"%0t: verdict beat mismatch: verdict %0d/%0d ",
								"mapper %0d/%0d size %0d/%0d (expected/actual)"},
								$realtime, want.verdict, got.verdict, want.mapper,
								got.mapper, want.size, got.size);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_FILE_LENGTH:      file_len = cfg_data;
					REG_MAX_IMAGE_LENGTH: max_len  = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				if (first_byte)
					next_pos = '0;
				// past offset 15 the beat is dropped until the next mark
				if (next_pos < HEADER_BYTES) begin
					stored_hdr[next_pos[3:0]] = header_byte;
					next_pos++;
					if (next_pos == HEADER_BYTES)
						expected_verdicts.push_back(grade_header(stored_hdr, file_len, max_len));
				end
			end
			mismatches <= err_count;
			pending    <= expected_verdicts.size();
		end
	end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
	import ihv_pkg::*;

	localparam int         LATENCY_CYCLES = 4;
	localparam int         WATCHDOG_LIMIT = 4000;
	localparam int         PHASE_BEATS    = 210;
	localparam cfg_index_t REG_UNMAPPED   = 2'd3;

	typedef enum int {FLAW_NONE, FLAW_MAGIC, FLAW_FORMAT, FLAW_RESERVED, FLAW_COUNTS} flaw_t;

	logic clk = 1'b0;
	logic arst_n;
	bit   calm = 1'b0;
	int   beats_sent = 0;
	int   idle_cycles = 0;
	int   mismatches;
	int   pending;

	ihv_byte_if    in_ch();
	ihv_verdict_if out_ch();
	ihv_cfg_if     cfg_ch();

	always #2 clk = ~clk;

	ines_header_validator_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg    (cfg_ch)
	);

	ihv_header_checker u_verdict_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_ch.valid),
		.in_ready      (in_ch.ready),
		.header_byte   (in_ch.header_byte),
		.first_byte    (in_ch.first_byte),
		.out_valid     (out_ch.valid),
		.out_ready     (out_ch.ready),
		.verdict       (out_ch.verdict),
		.mapper_id     (out_ch.mapper_id),
		.image_size    (out_ch.image_size),
		.cfg_valid     (cfg_ch.valid),
		.cfg_ready     (cfg_ch.ready),
		.cfg_index     (cfg_ch.index),
		.cfg_data      (cfg_ch.data),
		.mismatches    (mismatches),
		.pending       (pending)
	);

	function automatic logic [7:0] known_mapper(int k);
		case (k)
			0: return 8'd0;
			1: return 8'd1;
			2: return 8'd2;
			3: return 8'd3;
			4: return 8'd4;
			5: return 8'd5;
			6: return 8'd7;
			7: return 8'd9;
			8: return 8'd10;
			9: return 8'd11;
			10: return 8'd23;
			11: return 8'd24;
			default: return 8'd66;
		endcase
	endfunction

	function automatic hdr_t clean_header(logic [7:0] mapper, logic [7:0] prg,
			logic [7:0] chr, logic trainer);
		hdr_t h;
		h       = '0;
		h[3:0]  = MAGIC_TAG;
		h[4]    = prg;
		h[5]    = chr;
		h[6]    = {mapper[3:0], 1'b0, trainer, 2'b00};
		h[7]    = {mapper[7:4], 4'h0};
		return h;
	endfunction

	function automatic hdr_t make_header();
		hdr_t       h;
		logic [7:0] mapper;
		logic [7:0] prg;
		flaw_t      flaw;
		mapper = ($urandom_range(0, 9) != 0) ? known_mapper($urandom_range(0, 12))
			: 8'($urandom_range(0, 255));
		prg = ($urandom_range(0, 19) != 0) ? 8'($urandom_range(1, 16)) : 8'hff;
		h = clean_header(mapper, prg, 8'($urandom_range(0, 8)), 1'($urandom));
		h[6][3] = 1'($urandom);
		h[6][1:0] = 2'($urandom);
		h[8] = 8'($urandom_range(0, 8));
		h[9] = 8'($urandom);
		h[10] = 8'($urandom);
		h[11] = 8'($urandom);
		if ($urandom_range(0, 9) == 0)
			h[15:7] = RIPPER_TAG;
		flaw = ($urandom_range(0, 9) < 6) ? FLAW_NONE : flaw_t'($urandom_range(1, 4));
		case (flaw)
			FLAW_MAGIC:    h[$urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
			FLAW_FORMAT:   h[7][3:0] = 4'($urandom_range(1, 15));
			FLAW_RESERVED: h[$urandom_range(12, 15)] = 8'($urandom_range(1, 255));
			FLAW_COUNTS: begin
				if ($urandom_range(0, 1) != 0)
					h[4] = 8'h00;
				else
					h[8] = 8'($urandom_range(9, 255));
			end
			default: ;
		endcase
		return h;
	endfunction

	task automatic send_beat(logic [7:0] b, logic f);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid       <= 1'b1;
		in_ch.header_byte <= b;
		in_ch.first_byte  <= f;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		beats_sent++;
	endtask

	task automatic send_header(hdr_t h, logic mark, int count = 16);
		for (int i = 0; i < count; i++)
			send_beat(h[i], (i == 0) ? mark : 1'b0);
	endtask

	// hold input low until every verdict has come back, then let the pipe settle
	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (LATENCY_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(cfg_index_t idx, logic [LEN_W-1:0] val, logic last);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		if (last)
			cfg_ch.valid <= 1'b0;
	endtask

	task automatic set_limits(logic [LEN_W-1:0] flen, logic [LEN_W-1:0] maxl);
		cfg_write(REG_FILE_LENGTH, flen, 1'b0);
		cfg_write(REG_MAX_IMAGE_LENGTH, maxl, 1'b1);
	endtask

	task automatic random_phase(int budget, logic pause_midway);
		int   target;
		int   n;
		logic paused;
		target = beats_sent + budget;
		paused = 1'b0;
		while (beats_sent < target) begin
			if ($urandom_range(0, 15) == 0)
				calm = !calm;
			case ($urandom_range(0, 19))
				0: begin
					n = $urandom_range(1, 20);
					repeat (n) send_beat(8'($urandom), 1'($urandom_range(0, 3) == 0));
				end
				1: send_header(make_header(), 1'b1, $urandom_range(1, 15));
				default: begin
					send_header(make_header(), 1'($urandom_range(0, 9) != 0));
					if ($urandom_range(0, 7) == 0) begin
						n = $urandom_range(1, 3);
						repeat (n) send_beat(8'($urandom), 1'b0);
					end
				end
			endcase
			if (pause_midway && !paused && beats_sent > target - budget / 2) begin
				drain();
				paused = 1'b1;
			end
		end
		// close on a whole header so no header is in flight across the write
		send_header(make_header(), 1'b1);
		drain();
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
					|| (cfg_ch.valid && cfg_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	initial begin
		int stall;
		out_ch.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 14);
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			@(posedge clk);
			while (!out_ch.valid) @(posedge clk);
		end
	end

	initial begin
		hdr_t h;
		arst_n            <= 1'b0;
		in_ch.valid       <= 1'b0;
		in_ch.header_byte <= '0;
		in_ch.first_byte  <= 1'b0;
		cfg_ch.valid      <= 1'b0;
		cfg_ch.index      <= REG_FILE_LENGTH;
		cfg_ch.data       <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset limits reject any file; first header goes in without the mark
		send_header(clean_header(8'd0, 8'd1, 8'd1, 1'b0), 1'b0);
		drain();
		set_limits(24'd6267408, MAX_IMAGE_LENGTH_RST);
		send_header(clean_header(8'd4, 8'd2, 8'd1, 1'b1), 1'b1);
		send_header(clean_header(8'd66, 8'd255, 8'd255, 1'b1), 1'b1);
		h = clean_header(8'd0, 8'd1, 8'd0, 1'b0);
		h[3] = 8'h1b;
		send_header(h, 1'b1);
		h = clean_header(8'd1, 8'd1, 8'd1, 1'b0);
		h[7][3:0] = 4'h8;
		send_header(h, 1'b1);
		h[7][3:0] = 4'h1;
		send_header(h, 1'b1);
		h = clean_header(8'd2, 8'd8, 8'd0, 1'b0);
		h[15:7] = RIPPER_TAG;
		send_header(h, 1'b1);
		h = clean_header(8'd3, 8'd2, 8'd2, 1'b0);
		h[15] = 8'h80;
		send_header(h, 1'b1);
		h[15] = 8'h00;
		h[4]  = 8'h00;
		send_header(h, 1'b1);
		h[4] = 8'h01;
		h[8] = 8'd9;
		send_header(h, 1'b1);
		h[8] = 8'd8;
		send_header(h, 1'b1);
		send_header(clean_header(8'd6, 8'd1, 8'd1, 1'b0), 1'b1);
		send_header(clean_header(8'hff, 8'd1, 8'd1, 1'b1), 1'b1);
		// restart after six bytes, then beats past offset 15 are dropped
		send_header(clean_header(8'd7, 8'd4, 8'd0, 1'b0), 1'b1, 6);
		send_header(clean_header(8'd9, 8'd4, 8'd2, 1'b0), 1'b1);
		send_beat(8'hff, 1'b0);
		send_beat(8'h00, 1'b0);
		drain();
		set_limits(24'd6267407, 24'hffffff);
		send_header(clean_header(8'd66, 8'd255, 8'd255, 1'b1), 1'b1);
		drain();
		set_limits(24'd17, 24'd16);
		send_header(clean_header(8'd0, 8'd1, 8'd0, 1'b0), 1'b1);
		drain();

		set_limits(24'hffffff, 24'hffffff);
		random_phase(PHASE_BEATS, 1'b1);
		set_limits(24'd16, 24'd16);
		random_phase(PHASE_BEATS, 1'b0);
		set_limits(24'd0, 24'hffffff);
		random_phase(PHASE_BEATS, 1'b0);
		cfg_write(REG_UNMAPPED, 24'($urandom), 1'b0);
		set_limits(24'($urandom_range(16, 24'hffffff)), 24'($urandom_range(16, 24'hffffff)));
		random_phase(PHASE_BEATS, 1'b0);
		set_limits(24'd6267408, MAX_IMAGE_LENGTH_RST);
		random_phase(PHASE_BEATS, 1'b0);
		set_limits(24'($urandom_range(16, 300000)), 24'hffffff);
		random_phase(PHASE_BEATS, 1'b0);

		if (mismatches == 0 && pending == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/ihv_pkg.sv
hw/rtl/ihv_if.sv
hw/rtl/ihv_capture.sv
hw/rtl/ihv_judge.sv
hw/rtl/ines_header_validator_unit.sv
tb/ihv_header_checker.sv
tb/tb_top.sv
